// ===== hw/rtl/binary_grid_boundary_cell_count_assert.svh =====
// Assertion macros for the boundary cell counter RTL.
// Clock and reset are passed in, so the macros need nothing else.
`ifndef BINARY_GRID_BOUNDARY_CELL_COUNT_ASSERT_SVH
`define BINARY_GRID_BOUNDARY_CELL_COUNT_ASSERT_SVH

// Checked only while reset is low.
`define BGBC_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Checked on every edge, reset included.
`define BGBC_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== hw/rtl/bgbc_pkg.sv =====
// Shared types, constants and the cell classifier for the boundary cell counter.
// No dependencies.
package bgbc_pkg;

  localparam int MAX_COLS_DEF = 1024;

  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 23;
  localparam int ROWS_W  = 13;
  localparam int COLS_W  = 11;
  localparam int ROW_W   = 12;   // row index, up to 4096 rows
  localparam int COLI_W  = 12;   // widest column index over the MAX_COLS range
  localparam int MAX_ROWS = 4096;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // register byte addresses
  localparam logic [ADDR_W-1:0] REG_GRID_ROWS = 3'd0;
  localparam logic [ADDR_W-1:0] REG_GRID_COLS = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_LAND  = 8'h23;
  localparam logic [CHAR_W-1:0] CHAR_WATER = 8'h2E;

  typedef logic [1:0] cls_t;
  localparam cls_t CLS_OTHER = 2'd0;
  localparam cls_t CLS_LAND  = 2'd1;
  localparam cls_t CLS_WATER = 2'd2;

  // one line store entry: class two rows up and one row up
  typedef struct packed {
    cls_t upper;
    cls_t middle;
  } row_ent_t;

  // frame geometry handed from the register block to the scanner
  typedef struct packed {
    logic              clear;
    logic [ROW_W-1:0]  row_last;
    logic [COLI_W-1:0] col_last;
  } geom_t;

  function automatic cls_t classify(input logic [CHAR_W-1:0] ch);
    cls_t c;
    c = CLS_OTHER;
    if (ch == CHAR_LAND) c = CLS_LAND;
    else if (ch == CHAR_WATER) c = CLS_WATER;
    return c;
  endfunction

endpackage

// ===== hw/rtl/bgbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bgbc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bgbc_cfg.sv =====
// Configuration registers of the boundary cell counter, on an APB-style port.
// Depends on bgbc_pkg; turns row and column counts into last-index values.
module bgbc_cfg #(
  parameter int MAX_COLS = bgbc_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgbc_pkg::ADDR_W-1:0] paddr,
  input  logic [bgbc_pkg::DATA_W-1:0] pwdata,
  output logic [bgbc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output bgbc_pkg::geom_t             geom
);

  logic [bgbc_pkg::ROWS_W-1:0] grid_rows;
  logic [bgbc_pkg::COLS_W-1:0] grid_cols;
  logic [bgbc_pkg::ROW_W-1:0]  row_last;
  logic [bgbc_pkg::COLI_W-1:0] col_last;
  logic                        wr;
  logic                        sel_cols;
  logic [bgbc_pkg::ROWS_W-1:0] rows_in;
  logic [12:0]                 cols_in;
  logic [bgbc_pkg::ROW_W-1:0]  row_last_next;
  logic [bgbc_pkg::COLI_W-1:0] col_last_next;

  assign pready   = 1'b1;
  assign wr       = psel & penable & pwrite & pready;
  // two registers, four bytes apart
  assign sel_cols = paddr[2];

  assign rows_in = pwdata[bgbc_pkg::ROWS_W-1:0];
  assign cols_in = {2'b00, pwdata[bgbc_pkg::COLS_W-1:0]};

  always_comb begin
    if (rows_in == '0) begin
      row_last_next = '0;
    end else if (rows_in > 13'(bgbc_pkg::MAX_ROWS)) begin
      row_last_next = bgbc_pkg::ROW_W'(bgbc_pkg::MAX_ROWS - 1);
    end else begin
      row_last_next = bgbc_pkg::ROW_W'(rows_in - 13'd1);
    end
  end

  always_comb begin
    if (cols_in == '0) begin
      col_last_next = '0;
    end else if (cols_in > 13'(MAX_COLS)) begin
      col_last_next = bgbc_pkg::COLI_W'(MAX_COLS - 1);
    end else begin
      col_last_next = bgbc_pkg::COLI_W'(cols_in - 13'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= bgbc_pkg::ROWS_W'(1);
      grid_cols <= bgbc_pkg::COLS_W'(1);
      row_last  <= '0;
      col_last  <= '0;
    end else begin
      if (wr) begin
        if (sel_cols) begin
          grid_cols <= pwdata[bgbc_pkg::COLS_W-1:0];
          col_last  <= col_last_next;
        end else begin
          grid_rows <= rows_in;
          row_last  <= row_last_next;
        end
      end
    end
  end

  always_comb begin
    if (sel_cols) prdata = {{(bgbc_pkg::DATA_W-bgbc_pkg::COLS_W){1'b0}}, grid_cols};
    else          prdata = {{(bgbc_pkg::DATA_W-bgbc_pkg::ROWS_W){1'b0}}, grid_rows};
  end

  // any write drops the frame in progress, at the edge that loads the new geometry
  assign geom.clear    = wr;
  assign geom.row_last = row_last;
  assign geom.col_last = col_last;

endmodule

// ===== hw/rtl/bgbc_scan.sv =====
// Raster scanner: cell classification, line store, neighbor window and count.
// Depends on bgbc_pkg, bgbc_ram and the assertion macro header.
`include "binary_grid_boundary_cell_count_assert.svh"

module bgbc_scan #(
  parameter int MAX_COLS = bgbc_pkg::MAX_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bgbc_pkg::geom_t              geom,
  input  logic                         accept,
  input  logic [bgbc_pkg::CHAR_W-1:0]  cell_char,
  output logic                         frame_end,
  output logic                         res_valid,
  output logic [bgbc_pkg::COUNT_W-1:0] res_count
);

  localparam int CW = $clog2(MAX_COLS);

  logic [bgbc_pkg::ROW_W-1:0]   row;
  logic [CW-1:0]                col;
  logic [bgbc_pkg::COUNT_W-1:0] count;
  bgbc_pkg::cls_t               mid_l;
  bgbc_pkg::row_ent_t           ent_cur;
  bgbc_pkg::row_ent_t           col0_ent;
  logic                         fwd_valid;
  bgbc_pkg::row_ent_t           fwd_data;

  logic [CW-1:0]                col_last;
  logic [CW-1:0]                col_next;
  logic [bgbc_pkg::ROW_W-1:0]   row_next;
  logic [CW-1:0]                raddr;
  bgbc_pkg::row_ent_t           rd_ent;
  bgbc_pkg::row_ent_t           ahead;
  bgbc_pkg::row_ent_t           wr_ent;
  bgbc_pkg::cls_t               cur;
  bgbc_pkg::cls_t               mid;
  bgbc_pkg::cls_t               up;
  logic                         at_col0;
  logic                         at_col_last;
  logic                         at_row_last;
  logic                         edge_hit;
  logic                         int_hit;
  logic [bgbc_pkg::COUNT_W-1:0] count_sum;

  assign col_last    = geom.col_last[CW-1:0];
  assign cur         = bgbc_pkg::classify(cell_char);
  assign at_col0     = (col == '0);
  assign at_col_last = (col == col_last);
  assign at_row_last = (row == geom.row_last);
  assign frame_end   = at_col_last & at_row_last;

  // ent_cur holds the store entry at this column, ahead the one to its right
  assign mid   = (row != '0) ? ent_cur.middle : bgbc_pkg::CLS_OTHER;
  assign up    = (row > bgbc_pkg::ROW_W'(1)) ? ent_cur.upper : bgbc_pkg::CLS_OTHER;
  assign ahead = fwd_valid ? fwd_data : rd_ent;

  assign wr_ent.upper  = mid;
  assign wr_ent.middle = cur;

  assign edge_hit = (cur == bgbc_pkg::CLS_LAND) &&
                    ((row == '0) || at_row_last || at_col0 || at_col_last);

  // decide the cell above the arriving one
  assign int_hit = (row > bgbc_pkg::ROW_W'(1)) && !at_col0 && !at_col_last &&
                   (mid == bgbc_pkg::CLS_LAND) &&
                   ((up == bgbc_pkg::CLS_WATER) || (cur == bgbc_pkg::CLS_WATER) ||
                    (mid_l == bgbc_pkg::CLS_WATER) ||
                    (ahead.middle == bgbc_pkg::CLS_WATER));

  assign count_sum = count + bgbc_pkg::COUNT_W'(edge_hit)
                           + bgbc_pkg::COUNT_W'(int_hit);

  always_comb begin
    if (at_col_last) begin
      col_next = '0;
      row_next = at_row_last ? '0 : row + bgbc_pkg::ROW_W'(1);
    end else begin
      col_next = col + CW'(1);
      row_next = row;
    end
  end

  // look one column past the next cell; wraps harmlessly at the last column
  assign raddr = (accept ? col_next : col) + CW'(1);

  bgbc_ram #(
    .WIDTH($bits(bgbc_pkg::row_ent_t)),
    .DEPTH(MAX_COLS)
  ) u_line (
    .clk  (clk),
    .we   (accept),
    .waddr(col),
    .wdata(wr_ent),
    .raddr(raddr),
    .rdata(rd_ent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      count     <= '0;
      mid_l     <= bgbc_pkg::CLS_OTHER;
      fwd_valid <= 1'b0;
    end else begin
      // bypass a write that lands on the entry being read
      fwd_valid <= accept && (col == raddr);
      if (geom.clear) begin
        row   <= '0;
        col   <= '0;
        count <= '0;
        mid_l <= bgbc_pkg::CLS_OTHER;
      end else if (accept) begin
        row   <= row_next;
        col   <= col_next;
        count <= frame_end ? '0 : count_sum;
        mid_l <= at_col_last ? bgbc_pkg::CLS_OTHER : mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr_ent;
    if (accept) begin
      if (at_col0) col0_ent <= wr_ent;
      if (!at_col_last)  ent_cur <= ahead;
      else if (at_col0)  ent_cur <= wr_ent;
      else               ent_cur <= col0_ent;
    end
  end

  assign res_valid = accept & frame_end & ~geom.clear;
  assign res_count = count_sum;

  `BGBC_ASSERT(a_col_in_frame, clk, rst, col <= col_last, "column index past last column")
  `BGBC_ASSERT(a_row_in_frame, clk, rst, row <= geom.row_last, "row index past last row")
  `BGBC_ASSERT(a_clear_after_result, clk, rst,
    res_valid |=> (row == '0 && col == '0 && count == '0), "frame state kept after result")
  `BGBC_ASSERT_ALWAYS(a_reset_home, clk,
    rst |=> (row == '0 && col == '0 && count == '0 && !fwd_valid), "reset left state")

endmodule

// ===== hw/rtl/binary_grid_boundary_cell_count.sv =====
// Boundary land cell counter for a character grid streamed in raster order.
// Slave stream: one cell byte per transaction in s_tdata[7:0] ('#' land, '.' water,
// anything else neither), rows top to bottom, columns left to right.
// Master stream: one transaction per frame, m_tdata[22:0] = count of land cells that
// sit on the grid edge or touch water above, below, left or right.
// APB port: grid_rows at 0x0, grid_cols at 0x4; any write abandons the frame in
// progress. Values of zero act as 1; values above 4096 rows or MAX_COLS columns clamp.
// Throughput: one cell per cycle while s_tready is high. Each cell does one read
// and one write of a single line store RAM holding two rows of cell classes; the
// read runs one column ahead. The count is registered onto m_tvalid and m_tdata.
// Reset: frame position and count clear, geometry returns to 1 x 1, no result pending;
// the line store needs no clearing since each entry is written before it is read.
// Stall: s_tready stays high while a count waits on m_tready; only the last cell of
// the next frame is held off until the waiting count is taken.
module binary_grid_boundary_cell_count #(
  parameter int MAX_COLS = bgbc_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgbc_pkg::ADDR_W-1:0] paddr,
  input  logic [bgbc_pkg::DATA_W-1:0] pwdata,
  output logic [bgbc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // cell stream in
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] cell_char
  // count stream out
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata    // [22:0] boundary_count, [23] zero
);

  bgbc_pkg::geom_t              geom;
  logic                         accept;
  logic                         frame_end;
  logic                         res_valid;
  logic [bgbc_pkg::COUNT_W-1:0] res_count;
  logic [bgbc_pkg::COUNT_W-1:0] out_count;

  bgbc_cfg #(
    .MAX_COLS(MAX_COLS)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .geom   (geom)
  );

  // hold off only the transaction that would produce a second pending count
  assign s_tready = ~(frame_end & m_tvalid & ~m_tready);
  assign accept   = s_tvalid & s_tready;

  bgbc_scan #(
    .MAX_COLS(MAX_COLS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .accept   (accept),
    .cell_char(s_tdata),
    .frame_end(frame_end),
    .res_valid(res_valid),
    .res_count(res_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_count <= res_count;
  end

  assign m_tdata = {1'b0, out_count};

endmodule
